@@ src/mass_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mass_pkg: shared types and constants of the move supervisor
// Item and result structs, configuration set, phase and status codes.
// ----------------------------------------------------------------------------
package mass_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 32;

  // Configuration register indexes.
  localparam logic [CfgIndexWidth-1:0] CFG_TIMEOUT_LIMIT  = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_LOAD_THRESHOLD = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_ARRIVE_WINDOW  = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_SPEED_GATE     = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CFG_STALL_REPEATS  = 3'd4;
  localparam logic [CfgIndexWidth-1:0] CFG_BOOT_LIMIT     = 3'd5;
  localparam logic [CfgIndexWidth-1:0] CFG_SETTLE         = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [31:0] TIMEOUT_LIMIT_RESET  = 32'd10000;
  localparam logic [9:0]  LOAD_THRESHOLD_RESET = 10'd100;
  localparam logic [15:0] ARRIVE_WINDOW_RESET  = 16'd256;
  localparam logic [22:0] SPEED_GATE_RESET     = 23'd20000;
  localparam logic [2:0]  STALL_REPEATS_RESET  = 3'd3;
  localparam logic [9:0]  BOOT_LIMIT_RESET     = 10'd800;
  localparam logic [9:0]  SETTLE_RESET         = 10'd200;

  localparam logic [9:0]  TIMER_MAX   = 10'h3FF;
  localparam logic [31:0] ELAPSED_MAX = 32'hFFFF_FFFF;
  localparam logic [2:0]  COUNT_MAX   = 3'd7;

  // Operation codes of an input item.
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_BOOT    = 2'd1,
    PH_SETTLE  = 2'd2,
    PH_MONITOR = 2'd3
  } mass_phase_t;

  typedef enum logic [2:0] {
    ST_BUSY    = 3'd0,
    ST_ARRIVED = 3'd1,
    ST_STALLED = 3'd2,
    ST_TIMEOUT = 3'd3,
    ST_IDLE    = 3'd4
  } mass_status_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] target_position;
    logic signed [31:0] actual_position;
    logic signed [23:0] actual_velocity;
    logic [9:0]         load_value;
  } mass_in_t;

  typedef struct packed {
    logic [2:0] move_status;
    logic       stop_request;
    logic [1:0] phase_now;
  } mass_out_t;

  typedef struct packed {
    logic [31:0] timeout_limit_ms;
    logic [9:0]  load_threshold;
    logic [15:0] arrive_window;
    logic [22:0] stall_speed_gate;
    logic [2:0]  stall_repeats;
    logic [9:0]  boot_limit_ms;
    logic [9:0]  settle_ms;
  } mass_cfg_t;

endpackage
`default_nettype wire

@@ src/motion_arrival_stall_supervisor_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// motion_arrival_stall_supervisor_unit: positioning move supervisor
// Tracks boot, settle and monitor phases of one move and returns a status
// for each start, tick or sample; arrival, stall and timeout come from samples.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  in       input      in_valid / in_stall    mass_in_t (op, positions, velocity, load)
//  out      output     out_valid / out_stall  mass_out_t (status, stop, phase)
//  cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle is accepted into the input register while in_stall is
// low; its result is loaded into the result register when the item moves on
// and leaves from there. The update of the move state is combinational
// logic between those registers. Reset is synchronous and leaves the block
// idle with default settings. A stalled result holds the result register,
// and the input register keeps the next item behind it.
// ----------------------------------------------------------------------------
module motion_arrival_stall_supervisor_unit
  import mass_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  mass_in_t                      in_data,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output mass_out_t                     out_data,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [CfgDataWidth-1:0]  cfg_data
);

  mass_cfg_t cfg;
  logic      s1_valid;
  mass_in_t  s1_item;
  logic      s1_advance;
  mass_out_t step_result;

  assign cfg_ready = 1'b1;

  mass_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The held item moves on whenever the result register is free or being emptied.
  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item <= in_data;
    end
  end

  mass_step u_step (
    .clk     (clk),
    .rst     (rst),
    .advance (s1_advance),
    .item    (s1_item),
    .cfg     (cfg),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_data <= step_result;
    end
  end

endmodule
`default_nettype wire

@@ src/mass_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mass_cfg_regs: configuration register file
// Holds the seven supervisor settings; each write is registered.
// ----------------------------------------------------------------------------
module mass_cfg_regs
  import mass_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     wr_en,
  input  wire logic [CfgIndexWidth-1:0] wr_index,
  input  wire logic [CfgDataWidth-1:0]  wr_data,
  output mass_cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_limit_ms <= TIMEOUT_LIMIT_RESET;
      cfg.load_threshold   <= LOAD_THRESHOLD_RESET;
      cfg.arrive_window    <= ARRIVE_WINDOW_RESET;
      cfg.stall_speed_gate <= SPEED_GATE_RESET;
      cfg.stall_repeats    <= STALL_REPEATS_RESET;
      cfg.boot_limit_ms    <= BOOT_LIMIT_RESET;
      cfg.settle_ms        <= SETTLE_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_TIMEOUT_LIMIT:  cfg.timeout_limit_ms <= wr_data;
        CFG_LOAD_THRESHOLD: cfg.load_threshold   <= wr_data[9:0];
        CFG_ARRIVE_WINDOW:  cfg.arrive_window    <= wr_data[15:0];
        CFG_SPEED_GATE:     cfg.stall_speed_gate <= wr_data[22:0];
        CFG_STALL_REPEATS:  cfg.stall_repeats    <= wr_data[2:0];
        CFG_BOOT_LIMIT:     cfg.boot_limit_ms    <= wr_data[9:0];
        CFG_SETTLE:         cfg.settle_ms        <= wr_data[9:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/mass_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mass_step: move state and per-item update
// Holds phase, target, timers and stall count; computes one result per item.
// ----------------------------------------------------------------------------
module mass_step
  import mass_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic advance,
  input  mass_in_t  item,
  input  mass_cfg_t cfg,
  output mass_out_t result
);

  mass_phase_t  phase, phase_next;
  logic [31:0]  target_hold, target_hold_next;
  logic [31:0]  elapsed_ms, elapsed_ms_next;
  logic [9:0]   phase_timer, phase_timer_next;
  logic [2:0]   low_load_count, low_load_count_next;
  mass_status_t status;
  logic         stop;

  logic [31:0]        elapsed_inc;
  logic [9:0]         timer_inc;
  logic [2:0]         count_inc;
  logic signed [32:0] pos_err;
  logic signed [32:0] window_pos;
  logic signed [32:0] window_neg;
  logic               vel_zero;
  logic               in_window;
  logic [23:0]        speed;
  logic               stall_sample;

  assign elapsed_inc = (elapsed_ms != ELAPSED_MAX) ? elapsed_ms + 32'd1 : elapsed_ms;
  assign timer_inc   = (phase_timer < TIMER_MAX) ? phase_timer + 10'd1 : phase_timer;
  assign count_inc   = (low_load_count < COUNT_MAX) ? low_load_count + 3'd1 : low_load_count;

  // Position error is taken at 33 bits so that no pair of 32-bit values overflows.
  assign pos_err    = {item.actual_position[31], item.actual_position}
                    - {target_hold[31], target_hold};
  assign window_pos = {17'd0, cfg.arrive_window};
  assign window_neg = -window_pos;
  assign vel_zero   = (item.actual_velocity == 24'sd0);
  assign in_window  = (pos_err >= window_neg) && (pos_err <= window_pos);

  // The magnitude of the most negative velocity still fits in 24 unsigned bits.
  assign speed        = item.actual_velocity[23] ? 24'(-item.actual_velocity)
                                                 : 24'(item.actual_velocity);
  assign stall_sample = (speed > {1'b0, cfg.stall_speed_gate})
                     && (item.load_value < cfg.load_threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      target_hold    <= '0;
      elapsed_ms     <= '0;
      phase_timer    <= '0;
      low_load_count <= '0;
    end else if (advance) begin
      phase          <= phase_next;
      target_hold    <= target_hold_next;
      elapsed_ms     <= elapsed_ms_next;
      phase_timer    <= phase_timer_next;
      low_load_count <= low_load_count_next;
    end
  end

  always_comb begin
    phase_next          = phase;
    target_hold_next    = target_hold;
    elapsed_ms_next     = elapsed_ms;
    phase_timer_next    = phase_timer;
    low_load_count_next = low_load_count;
    status              = ST_BUSY;
    stop                = 1'b0;

    unique case (item.op)
      OP_START: begin
        target_hold_next    = item.target_position;
        elapsed_ms_next     = '0;
        low_load_count_next = '0;
        phase_next          = PH_BOOT;
        phase_timer_next    = '0;
      end
      OP_TICK: begin
        if (phase != PH_IDLE) begin
          elapsed_ms_next  = elapsed_inc;
          phase_timer_next = timer_inc;
          if (phase == PH_BOOT && timer_inc >= cfg.boot_limit_ms) begin
            phase_next       = PH_SETTLE;
            phase_timer_next = '0;
          end else if (phase == PH_SETTLE && timer_inc >= cfg.settle_ms) begin
            phase_next       = PH_MONITOR;
            phase_timer_next = '0;
          end
        end
      end
      OP_SAMPLE: begin
        if (phase == PH_BOOT) begin
          if (!vel_zero) begin
            phase_next       = PH_SETTLE;
            phase_timer_next = '0;
          end
        end else if (phase == PH_MONITOR) begin
          if (elapsed_ms >= cfg.timeout_limit_ms) begin
            status           = ST_TIMEOUT;
            stop             = 1'b1;
            phase_next       = PH_IDLE;
            phase_timer_next = '0;
          end else if (vel_zero && in_window) begin
            status           = ST_ARRIVED;
            phase_next       = PH_IDLE;
            phase_timer_next = '0;
          end else if (stall_sample) begin
            low_load_count_next = count_inc;
            if (count_inc >= cfg.stall_repeats) begin
              status           = ST_STALLED;
              stop             = 1'b1;
              phase_next       = PH_IDLE;
              phase_timer_next = '0;
            end
          end else begin
            low_load_count_next = '0;
          end
        end
      end
      default: ;
    endcase

    if (status == ST_BUSY && phase_next == PH_IDLE) begin
      status = ST_IDLE;
    end
  end

  assign result.move_status  = status;
  assign result.stop_request = stop;
  assign result.phase_now    = phase_next;

endmodule
`default_nettype wire

@@ tb/motion_arrival_stall_supervisor_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Move supervisor regression
// Feeds start, tick and sample items through the input channel, keeps a
// cycle-free model of the move phases in step with every accepted item, and
// compares each result field by field. Register settings change between
// groups of moves, and both channels idle at random.
// ----------------------------------------------------------------------------
module motion_arrival_stall_supervisor_unit_test;
  import mass_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam longint     POS_MIN     = -64'sd2147483648;
  localparam longint     POS_MAX     = 64'sd2147483647;
  localparam longint     VEL_MIN     = -64'sd8388608;
  localparam longint     VEL_MAX     = 64'sd8388607;
  localparam int         GROUPS      = 10;
  localparam int         GROUP_ITEMS = 50;
  localparam int         QUIET_LIMIT = 1000;

  logic clk;
  logic rst = 1'b1;

  logic      in_valid = 1'b0;
  logic      in_stall;
  mass_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  mass_out_t out_data;

  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0]  cfg_data = '0;

  motion_arrival_stall_supervisor_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Settings as the block holds them, updated once all seven writes are done.
  mass_cfg_t cfg_now = '{
    timeout_limit_ms: TIMEOUT_LIMIT_RESET,
    load_threshold:   LOAD_THRESHOLD_RESET,
    arrive_window:    ARRIVE_WINDOW_RESET,
    stall_speed_gate: SPEED_GATE_RESET,
    stall_repeats:    STALL_REPEATS_RESET,
    boot_limit_ms:    BOOT_LIMIT_RESET,
    settle_ms:        SETTLE_RESET
  };

  // Move state of the model.
  mass_phase_t        move_phase = PH_IDLE;
  logic signed [31:0] hold_target = '0;
  logic [31:0]        elapsed = '0;
  logic [9:0]         phase_timer = '0;
  logic [2:0]         low_load_run = '0;

  mass_in_t  move_items[$];
  mass_out_t expected_status[$];

  logic idle_on = 1'b0;
  int   send_gap = 0;
  int   hold_left = 0;
  int   quiet_cycles = 0;
  int   queued_count = 0;
  int   sent_count = 0;
  int   checked_count = 0;
  int   setting_count = 0;
  int   arrivals = 0;
  int   stalls = 0;
  int   timeouts = 0;
  int   errors = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Model of the supervisor
  // --------------------------------------------------------------------------
  function automatic void enter_phase(input mass_phase_t p);
    move_phase  = p;
    phase_timer = '0;
  endfunction

  function automatic mass_out_t supervise_step(input mass_in_t item);
    mass_out_t    res;
    mass_status_t status;
    logic         stop;
    longint       pos;
    longint       vel;
    longint       tgt;
    longint       win;
    longint       gate;
    status = ST_BUSY;
    stop   = 1'b0;
    pos    = $signed(item.actual_position);
    vel    = $signed(item.actual_velocity);
    tgt    = hold_target;
    win    = cfg_now.arrive_window;
    gate   = cfg_now.stall_speed_gate;
    case (item.op)
      OP_START: begin
        hold_target  = item.target_position;
        elapsed      = '0;
        low_load_run = '0;
        enter_phase(PH_BOOT);
      end
      OP_TICK: begin
        if (move_phase != PH_IDLE) begin
          if (elapsed != ELAPSED_MAX) elapsed = elapsed + 32'd1;
          if (phase_timer < TIMER_MAX) phase_timer = phase_timer + 10'd1;
          if (move_phase == PH_BOOT && phase_timer >= cfg_now.boot_limit_ms) begin
            enter_phase(PH_SETTLE);
          end else if (move_phase == PH_SETTLE && phase_timer >= cfg_now.settle_ms) begin
            enter_phase(PH_MONITOR);
          end
        end
      end
      OP_SAMPLE: begin
        if (move_phase == PH_BOOT) begin
          if (vel != 0) enter_phase(PH_SETTLE);
        end else if (move_phase == PH_MONITOR) begin
          if (elapsed >= cfg_now.timeout_limit_ms) begin
            status = ST_TIMEOUT;
            stop   = 1'b1;
            enter_phase(PH_IDLE);
          end else if (vel == 0 && pos >= tgt - win && pos <= tgt + win) begin
            status = ST_ARRIVED;
            enter_phase(PH_IDLE);
          end else if ((vel > gate || vel < -gate) &&
                       item.load_value < cfg_now.load_threshold) begin
            if (low_load_run < COUNT_MAX) low_load_run = low_load_run + 3'd1;
            if (low_load_run >= cfg_now.stall_repeats) begin
              status = ST_STALLED;
              stop   = 1'b1;
              enter_phase(PH_IDLE);
            end
          end else begin
            low_load_run = '0;
          end
        end
      end
      default: ;
    endcase
    if (status == ST_BUSY && move_phase == PH_IDLE) status = ST_IDLE;
    res.move_status  = status;
    res.stop_request = stop;
    res.phase_now    = move_phase;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Driver and monitor
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_status.push_back(supervise_step(in_data));
        sent_count++;
      end
      if (in_valid && in_stall) begin
        // A stalled transfer keeps its payload.
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (move_items.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= move_items.pop_front();
        send_gap = idle_on ? $urandom_range(0, 4) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    mass_out_t want;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        checked_count++;
        if (out_data.move_status == ST_ARRIVED) arrivals++;
        if (out_data.move_status == ST_STALLED) stalls++;
        if (out_data.move_status == ST_TIMEOUT) timeouts++;
        if (expected_status.size() == 0) begin
          $error("result with no item waiting: status %0d", out_data.move_status);
          errors++;
        end else begin
          want = expected_status.pop_front();
          if (out_data.move_status !== want.move_status) begin
            $error("move_status: expected %0d, got %0d", want.move_status,
                   out_data.move_status);
            errors++;
          end
          if (out_data.stop_request !== want.stop_request) begin
            $error("stop_request: expected %0d, got %0d", want.stop_request,
                   out_data.stop_request);
            errors++;
          end
          if (out_data.phase_now !== want.phase_now) begin
            $error("phase_now: expected %0d, got %0d", want.phase_now,
                   out_data.phase_now);
            errors++;
          end
        end
        hold_left = idle_on ? $urandom_range(0, 4) : 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("No transfer for %0d cycles, giving up", QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic mass_in_t make_item(input logic [1:0] op);
    mass_in_t    it;
    logic [31:0] r;
    it.op = op;
    it.target_position = $urandom;
    it.actual_position = $urandom;
    r = $urandom;
    it.actual_velocity = r[23:0];
    r = $urandom;
    it.load_value = r[9:0];
    return it;
  endfunction

  function automatic void queue_item(input mass_in_t it);
    move_items.push_back(it);
    queued_count++;
  endfunction

  function automatic void add_start(input longint tgt);
    mass_in_t it;
    it = make_item(OP_START);
    it.target_position = tgt[31:0];
    queue_item(it);
  endfunction

  function automatic void add_ticks(input int n);
    for (int i = 0; i < n; i++) queue_item(make_item(OP_TICK));
  endfunction

  function automatic void add_sample(input longint pos, input longint vel,
                                     input logic [9:0] load);
    mass_in_t it;
    it = make_item(OP_SAMPLE);
    it.actual_position = pos[31:0];
    it.actual_velocity = vel[23:0];
    it.load_value      = load;
    queue_item(it);
  endfunction

  function automatic longint any_velocity();
    logic [31:0] r;
    longint      v;
    r = $urandom;
    v = $signed(r[23:0]);
    return (v == 0) ? 1 : v;
  endfunction

  // Speed just past the gate; at the top gate only the most negative value passes.
  function automatic longint stall_velocity(input mass_cfg_t c);
    longint mag;
    mag = longint'(c.stall_speed_gate) + 1 + $urandom_range(0, 2000);
    if (mag > VEL_MAX) return VEL_MIN;
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  function automatic logic [9:0] stall_load(input mass_cfg_t c);
    logic [31:0] r;
    if (c.load_threshold == 0) return '0;
    case ($urandom_range(0, 2))
      0: return '0;
      1: return c.load_threshold - 10'd1;
      default: begin
        r = $urandom_range(0, c.load_threshold - 1);
        return r[9:0];
      end
    endcase
  endfunction

  function automatic longint near_target(input longint tgt, input longint off);
    longint p;
    p = tgt + off;
    if (p > POS_MAX || p < POS_MIN) p = tgt - off;
    return p;
  endfunction

  function automatic logic [9:0] any_load();
    logic [31:0] r;
    r = $urandom;
    return r[9:0];
  endfunction

  // One move from start through boot, then settle and monitor if settle is short.
  function automatic void gen_move();
    mass_cfg_t c;
    longint    tgt;
    longint    off;
    longint    win;
    longint    need;
    int        n;
    int        elapsed_gen;
    c   = cfg_now;
    win = c.arrive_window;
    case ($urandom_range(0, 5))
      0: tgt = POS_MIN;
      1: tgt = POS_MAX;
      default: tgt = $signed($urandom);
    endcase
    add_start(tgt);

    if (c.boot_limit_ms <= 20 && $urandom_range(0, 1)) begin
      n = (c.boot_limit_ms == 0) ? 1 : c.boot_limit_ms;
      add_ticks(n);
    end else begin
      n = (c.boot_limit_ms == 0) ? 0 :
          $urandom_range(0, (c.boot_limit_ms > 6) ? 5 : c.boot_limit_ms - 1);
      add_ticks(n);
      if ($urandom_range(0, 1)) add_sample($signed($urandom), 0, any_load());
      add_sample($signed($urandom), any_velocity(), any_load());
    end
    elapsed_gen = n;

    // A long settle delay is left unfinished; the next start takes over.
    if (c.settle_ms > 40) begin
      add_ticks($urandom_range(0, 5));
      return;
    end
    n = (c.settle_ms == 0) ? 1 : c.settle_ms;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) queue_item(make_item(OP_SAMPLE));
      add_ticks(1);
    end
    elapsed_gen += n;

    need = longint'(c.timeout_limit_ms) - elapsed_gen;
    case ($urandom_range(0, 3))
      0: begin
        for (int i = $urandom_range(0, 2); i > 0; i--) begin
          add_sample($signed($urandom), any_velocity(), any_load());
        end
        if ($urandom_range(0, 1)) add_sample(near_target(tgt, win + 1), 0, any_load());
        case ($urandom_range(0, 2))
          0: off = -win;
          1: off = win;
          default: off = longint'($urandom_range(0, 2 * c.arrive_window)) - win;
        endcase
        add_sample(near_target(tgt, off), 0, any_load());
      end
      1: begin
        n = ((c.stall_repeats == 0) ? 1 : c.stall_repeats) + $urandom_range(0, 1);
        for (int i = 0; i < n; i++) begin
          // Load at the threshold breaks the run of low-load samples.
          if (i == 1 && $urandom_range(0, 4) == 0) begin
            add_sample($signed($urandom), stall_velocity(c), c.load_threshold);
          end
          add_sample($signed($urandom), stall_velocity(c), stall_load(c));
        end
      end
      2: begin
        if (need <= 50) begin
          for (longint i = 0; i < need; i++) begin
            add_ticks(1);
            if ($urandom_range(0, 4) == 0) begin
              add_sample($signed($urandom), any_velocity(), any_load());
            end
          end
        end
        add_sample($signed($urandom), any_velocity(), any_load());
      end
      default: begin
        for (int i = $urandom_range(1, 4); i > 0; i--) begin
          if ($urandom_range(0, 1)) add_ticks(1);
          queue_item(make_item(OP_SAMPLE));
        end
      end
    endcase
  endfunction

  function automatic void fill_once();
    logic [31:0] r;
    if ($urandom_range(0, 9) < 8) begin
      gen_move();
    end else begin
      for (int i = $urandom_range(1, 3); i > 0; i--) begin
        r = $urandom;
        queue_item(make_item(r[1:0]));
      end
    end
  endfunction

  function automatic mass_cfg_t pick_setting(input int g);
    mass_cfg_t   c;
    logic [31:0] r;
    c.timeout_limit_ms = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(3, 60);
    r = $urandom_range(50, 1023);
    c.load_threshold = r[9:0];
    r = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 300);
    c.arrive_window = r[15:0];
    r = $urandom_range(0, 200000);
    c.stall_speed_gate = r[22:0];
    r = $urandom_range(0, 7);
    c.stall_repeats = r[2:0];
    r = $urandom_range(0, 8);
    c.boot_limit_ms = r[9:0];
    r = $urandom_range(0, 8);
    c.settle_ms = r[9:0];
    case (g)
      1: begin
        c.timeout_limit_ms = '0;
        c.load_threshold   = '0;
        c.arrive_window    = '0;
        c.stall_speed_gate = '0;
        c.stall_repeats    = COUNT_MAX;
      end
      2: begin
        c.timeout_limit_ms = ELAPSED_MAX;
        c.load_threshold   = 10'h3FF;
        c.arrive_window    = 16'hFFFF;
        c.stall_speed_gate = 23'h7FFFFF;
        c.stall_repeats    = 3'd1;
      end
      3: begin
        c.load_threshold = 10'h3FF;
        c.stall_repeats  = COUNT_MAX;
        c.boot_limit_ms  = TIMER_MAX;
        c.settle_ms      = TIMER_MAX;
      end
      4: c.stall_repeats = '0;
      default: ;
    endcase
    return c;
  endfunction

  task automatic program_regs(input mass_cfg_t c);
    logic [CfgIndexWidth-1:0] idx[7];
    logic [31:0]              val[7];
    logic [31:0]              junk;
    idx[0] = CFG_TIMEOUT_LIMIT;
    idx[1] = CFG_LOAD_THRESHOLD;
    idx[2] = CFG_ARRIVE_WINDOW;
    idx[3] = CFG_SPEED_GATE;
    idx[4] = CFG_STALL_REPEATS;
    idx[5] = CFG_BOOT_LIMIT;
    idx[6] = CFG_SETTLE;
    // Bits above each field's width carry noise that the block must drop.
    val[0] = c.timeout_limit_ms;
    junk = $urandom;
    val[1] = {junk[31:10], c.load_threshold};
    junk = $urandom;
    val[2] = {junk[31:16], c.arrive_window};
    junk = $urandom;
    val[3] = {junk[31:23], c.stall_speed_gate};
    junk = $urandom;
    val[4] = {junk[31:3], c.stall_repeats};
    junk = $urandom;
    val[5] = {junk[31:10], c.boot_limit_ms};
    junk = $urandom;
    val[6] = {junk[31:10], c.settle_ms};
    @(posedge clk);
    for (int i = 0; i < 7; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    cfg_now = c;
    setting_count++;
  endtask

  // Returns on a falling edge once every item has gone in and come back.
  task automatic wait_idle();
    @(negedge clk);
    while (move_items.size() != 0 || in_valid || expected_status.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    mass_cfg_t c;
    int        mark;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Default settings: idle inputs, the unused op, boot and settle entry,
    // and a restart while a move is active.
    add_sample(0, 0, '0);
    add_ticks(1);
    queue_item(make_item(OP_UNUSED));
    add_start(POS_MAX);
    queue_item(make_item(OP_UNUSED));
    add_sample(0, 0, 10'h3FF);
    add_sample(POS_MAX, VEL_MAX, '0);
    add_sample(POS_MIN, VEL_MIN, '0);
    add_start(POS_MIN);
    add_ticks(1);
    wait_idle();

    // Zero delays: arrival at the window edge, stall on the first low-load
    // sample, then a timeout after a sample that clears the count.
    c = '{timeout_limit_ms: 32'd6, load_threshold: 10'h3FF, arrive_window: 16'hFFFF,
          stall_speed_gate: '0, stall_repeats: '0, boot_limit_ms: '0, settle_ms: '0};
    program_regs(c);
    @(negedge clk);
    add_start(POS_MIN);
    add_ticks(2);
    add_sample(POS_MIN + 65535, 0, '0);
    add_start(POS_MAX);
    add_ticks(2);
    add_sample(0, 1, '0);
    add_start(0);
    add_ticks(2);
    add_sample(POS_MIN, 0, 10'h3FF);
    add_ticks(4);
    add_sample(0, VEL_MIN, '0);

    for (int g = 0; g < GROUPS; g++) begin
      wait_idle();
      program_regs(pick_setting(g));
      @(negedge clk);
      idle_on = (g % 3 != 0);
      mark = queued_count;
      while (queued_count - mark < GROUP_ITEMS / 2) fill_once();
      // Hold the sender until every outstanding result has come back.
      wait_idle();
      while (queued_count - mark < GROUP_ITEMS) fill_once();
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (expected_status.size() != 0) begin
      $error("%0d results never arrived", expected_status.size());
      errors++;
    end
    $display("Checked %0d results from %0d items across %0d register settings",
             checked_count, sent_count, setting_count);
    $display("Moves ended in %0d arrivals, %0d stalls and %0d timeouts",
             arrivals, stalls, timeouts);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/mass_pkg.sv
src/mass_cfg_regs.sv
src/mass_step.sv
src/motion_arrival_stall_supervisor_unit.sv
tb/motion_arrival_stall_supervisor_unit_test.sv
